[sv/q8r_pkg.sv]
package q8r_pkg;

  localparam int unsigned BlockCountBits = 20;
  localparam int unsigned ValuesPerBlock = 32;
  localparam int unsigned SumW = 60;
  localparam int unsigned CntW = BlockCountBits + 1;
  localparam int unsigned ScaleW = 40;
  localparam int unsigned ProdW = 48;
  localparam int unsigned IdxW = 5;

  localparam logic [ScaleW-1:0] OneQ24 = ScaleW'(64'h1 << 24);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_DIV,
    ST_RS_MUL,
    ST_RS_DIV,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic accum;
    logic avg_start;
    logic avg_finish;
    logic mul;
    logic val_start;
    logic val_store;
    logic next_idx;
    logic out_take;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_type;
    logic last;
    logic div_done;
    logic idx_last;
  } sts_t;

  // half -> Q16.24 magnitude; sign bit ignored
  function automatic logic [ScaleW-1:0] half_mag(input logic [15:0] h);
    logic [4:0] e;
    logic [10:0] m;
    e = h[14:10];
    m = {1'b1, h[9:0]};
    if (e == 5'd0) return ScaleW'(h[9:0]);
    return ScaleW'({29'd0, m} << (e - 5'd1));
  endfunction

endpackage

[sv/q8_block_to_tensor_requantizer.sv]
// Block-to-tensor int8 requantizer.
// Input channel (in_valid_i/in_ready_o): one word per block, a half scale and
// 32 int8 values. Output channel (out_valid_o/out_ready_i): one result word.
// Averaging pass (req_type 0): a block is loaded, then accumulated; the last
// block runs a divide of the scale sum by the count and yields the average.
// Rescaling pass (req_type 1): each of the 32 values takes a multiply step
// and a bit-serial divide by the unified scale; the shared serial divider
// handles one value at a time, and the next block waits for all 32.
// The result sits in an output register; the next block is accepted while it
// waits, and the block stalls only if a second result is ready before the
// first one is taken.
// Reset clears the sum and count, sets the unified scale to 1.0 and empties
// the output register.
module q8_block_to_tensor_requantizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [15:0] scale_half_i,
  input  logic [63:0] quants_lo_i,
  input  logic [63:0] quants_mid_lo_i,
  input  logic [63:0] quants_mid_hi_i,
  input  logic [63:0] quants_hi_i,
  input  logic        last_block_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [39:0] average_scale_o,
  output logic [63:0] rescaled_lo_o,
  output logic [63:0] rescaled_mid_lo_o,
  output logic [63:0] rescaled_mid_hi_o,
  output logic [63:0] rescaled_hi_o,
  output logic        last_result_o
);
  q8r_pkg::cmd_t cmd;
  q8r_pkg::sts_t sts;
  logic [255:0] res;

  q8r_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  q8r_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .req_type_i, .scale_half_i,
    .quants_i({quants_hi_i, quants_mid_hi_i, quants_mid_lo_i, quants_lo_i}),
    .last_block_i, .result_kind_o, .average_scale_o,
    .rescaled_o(res), .last_result_o
  );

  assign rescaled_lo_o = res[63:0];
  assign rescaled_mid_lo_o = res[127:64];
  assign rescaled_mid_hi_o = res[191:128];
  assign rescaled_hi_o = res[255:192];

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("accepted while busy");
  a_avg_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !result_kind_o) |-> last_result_o)
    else $error("average not marked last");
  a_avg_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !result_kind_o) |-> (average_scale_o != 40'd0))
    else $error("zero average");
`endif
endmodule

[sv/q8r_divider.sv]
// Restoring divider, one quotient bit per cycle over 60 bits.
module q8r_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [q8r_pkg::SumW-1:0]    num_i,
  input  logic [q8r_pkg::ScaleW-1:0]  den_i,
  output logic                        done_o,
  output logic [q8r_pkg::SumW-1:0]    quo_o
);
  logic [q8r_pkg::SumW-1:0] quo_q, quo_d;
  logic [q8r_pkg::ScaleW:0] rem_q, rem_d;
  logic [q8r_pkg::ScaleW-1:0] den_q, den_d;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [q8r_pkg::ScaleW:0] sh;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    sh = {rem_q[q8r_pkg::ScaleW-1:0], quo_q[q8r_pkg::SumW-1]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = 6'(q8r_pkg::SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quo_d = {quo_q[q8r_pkg::SumW-2:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[q8r_pkg::SumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quo_o = quo_d;
endmodule

[sv/q8r_datapath.sv]
// Accumulator, shared multiplier and divider, result registers.
module q8r_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  q8r_pkg::cmd_t                cmd_i,
  output q8r_pkg::sts_t                sts_o,
  input  logic                         req_type_i,
  input  logic [15:0]                  scale_half_i,
  input  logic [255:0]                 quants_i,
  input  logic                         last_block_i,
  output logic                         result_kind_o,
  output logic [q8r_pkg::ScaleW-1:0]   average_scale_o,
  output logic [255:0]                 rescaled_o,
  output logic                         last_result_o
);
  logic req_q, last_q, neg_q, fin_q;
  logic [q8r_pkg::ScaleW-1:0] mag_q;
  logic [255:0] qv_q, res_q;
  logic [q8r_pkg::SumW-1:0] sum_q;
  logic [q8r_pkg::CntW-1:0] cnt_q;
  logic [q8r_pkg::ScaleW-1:0] uni_q, avg_q;
  logic [q8r_pkg::IdxW-1:0] idx_q;
  logic [q8r_pkg::ProdW-1:0] prod;
  logic qneg_q;
  logic [15:0] h;
  logic [7:0] b, qmag, byte_v;
  logic qneg;
  logic div_start, div_done;
  logic [q8r_pkg::SumW-1:0] div_num, quo;
  logic [q8r_pkg::ScaleW-1:0] div_den, avg_v;
  logic cnt_ok;
  logic [q8r_pkg::SumW-1:0] sum_nx;
  logic [q8r_pkg::CntW-1:0] cnt_nx;

  assign h = scale_half_i;
  assign b = qv_q[{idx_q, 3'b000} +: 8];
  assign qneg = b[7];
  assign qmag = qneg ? 8'(9'd256 - {1'b0, b}) : b;
  assign prod = q8r_pkg::ProdW'(qmag) * q8r_pkg::ProdW'(mag_q);

  // sum, cnt + block if scale finite, >=0, nonzero, cnt<2^20
  assign cnt_ok = fin_q && !neg_q && mag_q != '0 && !cnt_q[q8r_pkg::CntW-1];
  assign sum_nx = cnt_ok ? sum_q + q8r_pkg::SumW'(mag_q) : sum_q;
  assign cnt_nx = cnt_ok ? cnt_q + 1'b1 : cnt_q;

  assign div_start = cmd_i.avg_start || cmd_i.val_start;
  assign div_num = cmd_i.avg_start ? sum_nx : q8r_pkg::SumW'(prod);
  assign div_den = cmd_i.avg_start ? q8r_pkg::ScaleW'(cnt_nx) : uni_q;

  q8r_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(quo)
  );

  // average and byte saturation
  always_comb begin
    avg_v = q8r_pkg::ScaleW'(quo);
    if (cnt_q == '0 || avg_v == '0) avg_v = q8r_pkg::OneQ24;
    if (qneg_q != neg_q) begin
      byte_v = (quo > 60'd128) ? 8'h80 : 8'(9'd256 - 9'(quo));
    end else begin
      byte_v = (quo > 60'd127) ? 8'd127 : 8'(quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      uni_q <= q8r_pkg::OneQ24;
      idx_q <= '0;
    end else begin
      if (cmd_i.accum) begin
        sum_q <= sum_nx;
        cnt_q <= cnt_nx;
      end
      if (cmd_i.avg_finish) begin
        uni_q <= avg_v;
        sum_q <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.load) idx_q <= '0;
      else if (cmd_i.next_idx) idx_q <= idx_q + 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      last_q <= last_block_i;
      neg_q <= h[15];
      fin_q <= (h[14:10] != 5'h1f);
      mag_q <= (h[14:10] == 5'h1f) ? '0 : q8r_pkg::half_mag(h);
      qv_q <= quants_i;
      res_q <= '0;
    end
    if (cmd_i.mul) qneg_q <= qneg;
    if (cmd_i.val_store && fin_q) res_q[{idx_q, 3'b000} +: 8] <= byte_v;
    if (cmd_i.avg_finish) avg_q <= avg_v;
    if (cmd_i.out_take) begin
      result_kind_o <= req_q;
      average_scale_o <= req_q ? '0 : avg_q;
      rescaled_o <= req_q ? res_q : '0;
      last_result_o <= req_q ? last_q : 1'b1;
    end
  end

  assign sts_o.req_type = req_q;
  assign sts_o.last = last_q;
  assign sts_o.div_done = div_done;
  assign sts_o.idx_last = (idx_q == '1);
endmodule

[sv/q8r_ctrl.sv]
// Sequencer: one block at a time.
module q8r_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  q8r_pkg::sts_t sts_i,
  output q8r_pkg::cmd_t cmd_o
);
  q8r_pkg::state_e state_q, state_d;
  logic accum_q, ov_q, ov_d, take;

  assign in_ready_o = (state_q == q8r_pkg::ST_IDLE) && !accum_q;
  assign out_valid_o = ov_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      q8r_pkg::ST_IDLE: if (accum_q) begin
        if (sts_i.req_type) state_d = q8r_pkg::ST_RS_MUL;
        else if (sts_i.last) state_d = q8r_pkg::ST_AVG_DIV;
      end
      q8r_pkg::ST_AVG_DIV: if (sts_i.div_done) state_d = q8r_pkg::ST_OUT;
      q8r_pkg::ST_RS_MUL: state_d = q8r_pkg::ST_RS_DIV;
      q8r_pkg::ST_RS_DIV: if (sts_i.div_done)
        state_d = sts_i.idx_last ? q8r_pkg::ST_OUT : q8r_pkg::ST_RS_MUL;
      q8r_pkg::ST_OUT: if (!ov_q || out_ready_i) state_d = q8r_pkg::ST_IDLE;
      default: state_d = q8r_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    cmd_o.load = in_valid_i && in_ready_o;
    cmd_o.accum = (state_q == q8r_pkg::ST_IDLE) && accum_q && !sts_i.req_type;
    cmd_o.avg_start = cmd_o.accum && sts_i.last;
    cmd_o.avg_finish = (state_q == q8r_pkg::ST_AVG_DIV) && sts_i.div_done;
    cmd_o.mul = (state_q == q8r_pkg::ST_RS_MUL);
    cmd_o.val_start = (state_q == q8r_pkg::ST_RS_MUL);
    cmd_o.val_store = (state_q == q8r_pkg::ST_RS_DIV) && sts_i.div_done;
    cmd_o.next_idx = cmd_o.val_store;
    take = (state_q == q8r_pkg::ST_OUT) && (!ov_q || out_ready_i);
    cmd_o.out_take = take;
    ov_d = take ? 1'b1 : (ov_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= q8r_pkg::ST_IDLE;
      accum_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      accum_q <= cmd_o.load;
      ov_q <= ov_d;
    end
  end
endmodule
